// ===== hw/rtl/rdr_pkg.sv =====
`default_nettype none

package rdr_pkg;

   // size defaults for the frame store
   localparam int MAX_WIDTH_DEFAULT  = 256;
   localparam int MAX_HEIGHT_DEFAULT = 256;

   // field widths
   localparam int FUNC_W     = 2;
   localparam int X_W        = 12;
   localparam int YB_W       = 13;
   localparam int DIM_W      = 12;
   localparam int SCALE_W    = 8;
   localparam int DIGIT_W    = 4;
   localparam int RGB_W      = 24;
   localparam int CANVAS_W   = 9;
   localparam int REQ_DATA_W = 88;
   localparam int CSR_INDEX_W = 2;

   // tdata bit positions of the request fields
   localparam int X_LSB     = 0;
   localparam int YB_LSB    = X_LSB + X_W;
   localparam int W_LSB     = YB_LSB + YB_W;
   localparam int H_LSB     = W_LSB + DIM_W;
   localparam int SCALE_LSB = H_LSB + DIM_W;
   localparam int DIGIT_LSB = SCALE_LSB + SCALE_W;
   localparam int RGB_LSB   = DIGIT_LSB + DIGIT_W;

   localparam int CANVAS_RESET = 256;
   localparam int Y_BIAS       = 1000;
   localparam int QUEUE_DEPTH  = 4;

   localparam logic [3:0] GLYPH_LAST_CELL = 4'd14;
   localparam logic [1:0] GLYPH_LAST_COL  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_CANVAS_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CANVAS_HEIGHT = 2'd1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_FILL  = 2'd1,
      FUNC_DIGIT = 2'd2,
      FUNC_READ  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      OP_PAINT = 2'd0,
      OP_SKIP  = 2'd1,
      OP_READ  = 2'd2
   } op_kind_type;

   // one clipped work item from the front to the back
   typedef struct packed {
      op_kind_type         kind;
      logic                last;
      logic                outside;
      logic [CANVAS_W-1:0] x0;
      logic [CANVAS_W-1:0] x1;
      logic [CANVAS_W-1:0] y0;
      logic [CANVAS_W-1:0] y1;
      logic [RGB_W-1:0]    color;
   } op_type;

   // 3x5 font, top row in the high bits, left column first
   function automatic logic [14:0] glyph_bits(input logic [DIGIT_W-1:0] digit);
      logic [14:0] g;
      unique case (digit)
         4'd0, 4'd10: g = 15'o75557;
         4'd1, 4'd11: g = 15'o26227;
         4'd2, 4'd12: g = 15'o71747;
         4'd3, 4'd13: g = 15'o71717;
         4'd4, 4'd14: g = 15'o55711;
         4'd5, 4'd15: g = 15'o74717;
         4'd6:        g = 15'o74757;
         4'd7:        g = 15'o71111;
         4'd8:        g = 15'o75757;
         4'd9:        g = 15'o75717;
      endcase
      return g;
   endfunction

   // zero becomes one, anything above the store size saturates
   function automatic logic [CANVAS_W-1:0] clamp_dim(input logic [CANVAS_W-1:0] v,
                                                    input logic [12:0] max_dim);
      logic [CANVAS_W-1:0] r;
      if (v == '0) begin
         r = CANVAS_W'(1);
      end else if ({4'b0, v} > max_dim) begin
         r = max_dim[CANVAS_W-1:0];
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rdr_queue.sv =====
`default_nettype none

module rdr_queue
   import rdr_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire op_type push_data,
   output logic        full,
   input  wire logic   pop,
   output logic        pop_valid,
   output op_type      pop_data
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

   op_type        entries [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign full      = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entries[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (PW+1)'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rdr_front.sv =====
`default_nettype none

module rdr_front
   import rdr_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
)(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   input  wire logic [FUNC_W-1:0]      req_tuser,
   input  wire logic                   csr_valid,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CANVAS_W-1:0]    csr_data,
   input  wire logic                   engine_ready,
   output logic                        q_push,
   output op_type                      q_data,
   input  wire logic                   q_full
);

   localparam logic [12:0] MAX_W13 = 13'(MAX_WIDTH);
   localparam logic [12:0] MAX_H13 = 13'(MAX_HEIGHT);
   localparam logic [CANVAS_W-1:0] CW_RESET =
      CANVAS_W'((CANVAS_RESET > MAX_WIDTH) ? MAX_WIDTH : CANVAS_RESET);
   localparam logic [CANVAS_W-1:0] CH_RESET =
      CANVAS_W'((CANVAS_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CANVAS_RESET);

   typedef enum logic [1:0] {
      F_IDLE = 2'b01,
      F_EMIT = 2'b10
   } front_state_type;

   front_state_type      state_ff, state_in;
   logic [CANVAS_W-1:0]  cw_ff, cw_in, ch_ff, ch_in;
   func_type             func_ff, func_in;
   logic [X_W-1:0]       x_ff, x_in;
   logic [YB_W-1:0]      yb_ff, yb_in;
   logic [DIM_W-1:0]     w_ff, w_in, h_ff, h_in;
   logic [SCALE_W-1:0]   s_ff, s_in;
   logic [DIGIT_W-1:0]   d_ff, d_in;
   logic [RGB_W-1:0]     color_ff, color_in;
   logic [3:0]           cell_ff, cell_in;
   logic [1:0]           col_ff, col_in;
   logic [9:0]           xoff_ff, xoff_in;
   logic [10:0]          yoff_ff, yoff_in;

   logic                 accept;
   logic [14:0]          glyph;
   logic [12:0]          bx;
   logic [13:0]          bx_end, x1c;
   logic [DIM_W-1:0]     bw, bh;
   logic signed [15:0]   by, by_end, y0c, y1c, ch_s;
   logic                 lit, x_empty, y_empty, outside;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == F_IDLE) && engine_ready;
   assign glyph      = glyph_bits(d_ff);

   // clip the current block against the canvas
   always_comb begin
      bx  = 13'(x_ff) + 13'(xoff_ff);
      by  = $signed({3'b0, yb_ff}) + $signed({5'b0, yoff_ff}) - $signed(16'(Y_BIAS));
      bw  = w_ff;
      bh  = h_ff;
      lit = 1'b1;
      unique case (func_ff)
         FUNC_CLEAR: begin
            bx = '0;
            by = '0;
            bw = DIM_W'(cw_ff);
            bh = DIM_W'(ch_ff);
         end
         FUNC_DIGIT: begin
            bw  = DIM_W'(s_ff);
            bh  = DIM_W'(s_ff);
            lit = glyph[GLYPH_LAST_CELL - cell_ff];
         end
         FUNC_FILL, FUNC_READ: begin
         end
      endcase
      ch_s    = $signed({7'b0, ch_ff});
      bx_end  = 14'(bx) + 14'(bw);
      x1c     = (bx_end > 14'(cw_ff)) ? 14'(cw_ff) : bx_end;
      x_empty = (x1c <= 14'(bx));
      by_end  = by + $signed({4'b0, bh});
      y0c     = by[15] ? '0 : by;
      y1c     = (by_end > ch_s) ? ch_s : by_end;
      y_empty = (y1c <= y0c);
      outside = by[15] || (bx >= 13'(cw_ff)) || (by >= ch_s);
   end

   always_comb begin
      q_data.x0      = bx[CANVAS_W-1:0];
      q_data.x1      = x1c[CANVAS_W-1:0];
      q_data.y0      = y0c[CANVAS_W-1:0];
      q_data.y1      = y1c[CANVAS_W-1:0];
      q_data.color   = color_ff;
      q_data.outside = outside;
      q_data.last    = (func_ff != FUNC_DIGIT) || (cell_ff == GLYPH_LAST_CELL);
      if (func_ff == FUNC_READ) begin
         q_data.kind = OP_READ;
      end else if (lit && !x_empty && !y_empty) begin
         q_data.kind = OP_PAINT;
      end else begin
         q_data.kind = OP_SKIP;
      end
   end

   assign q_push = (state_ff == F_EMIT) && !q_full;

   always_comb begin
      state_in = state_ff;
      func_in  = func_ff;
      x_in     = x_ff;
      yb_in    = yb_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      s_in     = s_ff;
      d_in     = d_ff;
      color_in = color_ff;
      cell_in  = cell_ff;
      col_in   = col_ff;
      xoff_in  = xoff_ff;
      yoff_in  = yoff_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = F_EMIT;
               func_in  = func_type'(req_tuser);
               x_in     = req_tdata[X_LSB +: X_W];
               yb_in    = req_tdata[YB_LSB +: YB_W];
               w_in     = req_tdata[W_LSB +: DIM_W];
               h_in     = req_tdata[H_LSB +: DIM_W];
               s_in     = req_tdata[SCALE_LSB +: SCALE_W];
               d_in     = req_tdata[DIGIT_LSB +: DIGIT_W];
               color_in = req_tdata[RGB_LSB +: RGB_W];
               cell_in  = '0;
               col_in   = '0;
               xoff_in  = '0;
               yoff_in  = '0;
            end
         end
         F_EMIT: begin
            if (q_push) begin
               if (q_data.last) begin
                  state_in = F_IDLE;
               end else begin
                  // step to the next glyph cell, row by row
                  cell_in = cell_ff + 4'd1;
                  if (col_ff == GLYPH_LAST_COL) begin
                     col_in  = '0;
                     xoff_in = '0;
                     yoff_in = yoff_ff + 11'(s_ff);
                  end else begin
                     col_in  = col_ff + 2'd1;
                     xoff_in = xoff_ff + 10'(s_ff);
                  end
               end
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      cw_in = cw_ff;
      ch_in = ch_ff;
      if (csr_valid && (csr_index == CSR_CANVAS_WIDTH)) begin
         cw_in = clamp_dim(csr_data, MAX_W13);
      end
      if (csr_valid && (csr_index == CSR_CANVAS_HEIGHT)) begin
         ch_in = clamp_dim(csr_data, MAX_H13);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cw_ff    <= CW_RESET;
         ch_ff    <= CH_RESET;
         cell_ff  <= '0;
         col_ff   <= '0;
         xoff_ff  <= '0;
         yoff_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cw_ff    <= cw_in;
         ch_ff    <= ch_in;
         cell_ff  <= cell_in;
         col_ff   <= col_in;
         xoff_ff  <= xoff_in;
         yoff_ff  <= yoff_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      x_ff     <= x_in;
      yb_ff    <= yb_in;
      w_ff     <= w_in;
      h_ff     <= h_in;
      s_ff     <= s_in;
      d_ff     <= d_in;
      color_ff <= color_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rdr_back.sv =====
`default_nettype none

module rdr_back
   import rdr_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
)(
   input  wire logic              clock,
   input  wire logic              reset,
   output logic                   engine_ready,
   input  wire logic              q_valid,
   input  wire op_type            q_data,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [RGB_W-1:0]       rsp_tdata,
   output logic                   rsp_tuser
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] STRIDE    = AW'(MAX_WIDTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   typedef enum logic [4:0] {
      B_INIT  = 5'b00001,
      B_IDLE  = 5'b00010,
      B_PAINT = 5'b00100,
      B_READ  = 5'b01000,
      B_RESP  = 5'b10000
   } back_state_type;

   logic [RGB_W-1:0]    frame_mem [DEPTH];

   back_state_type      state_ff, state_in;
   op_type              op_ff, op_in;
   logic [CANVAS_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [AW-1:0]       row_base_ff, row_base_in;
   logic [AW-1:0]       clr_addr_ff, clr_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RGB_W-1:0]    rsp_rgb_ff, rsp_rgb_in;
   logic                rsp_outside_ff, rsp_outside_in;
   logic [RGB_W-1:0]    rd_data_ff;

   logic                wr_en, rd_en, load_rsp;
   logic [AW-1:0]       mem_addr, pixel_addr;
   logic [RGB_W-1:0]    wr_data;
   logic                row_end, block_end;

   assign engine_ready = (state_ff != B_INIT);
   assign q_pop        = (state_ff == B_IDLE) && q_valid;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_rgb_ff;
   assign rsp_tuser    = rsp_outside_ff;

   assign pixel_addr = row_base_ff + AW'(px_ff);
   assign row_end    = ((CANVAS_W+1)'(px_ff) + 1'b1) == (CANVAS_W+1)'(op_ff.x1);
   assign block_end  = ((CANVAS_W+1)'(py_ff) + 1'b1) == (CANVAS_W+1)'(op_ff.y1);
   assign load_rsp   = (state_ff == B_RESP) && op_ff.last && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      wr_en    = 1'b0;
      wr_data  = op_ff.color;
      mem_addr = pixel_addr;
      rd_en    = (state_ff == B_READ) && !op_ff.outside;
      if (state_ff == B_INIT) begin
         wr_en    = 1'b1;
         wr_data  = '0;
         mem_addr = clr_addr_ff;
      end else if (state_ff == B_PAINT) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      row_base_in = row_base_ff;
      clr_addr_in = clr_addr_ff;
      unique case (state_ff)
         B_INIT: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (q_pop) begin
               op_in       = q_data;
               px_in       = q_data.x0;
               py_in       = q_data.y0;
               row_base_in = AW'(q_data.y0) * STRIDE;
               unique case (q_data.kind)
                  OP_PAINT: state_in = B_PAINT;
                  OP_READ:  state_in = B_READ;
                  default:  state_in = B_RESP;
               endcase
            end
         end
         B_PAINT: begin
            if (!row_end) begin
               px_in = px_ff + CANVAS_W'(1);
            end else if (block_end) begin
               state_in = B_RESP;
            end else begin
               px_in       = op_ff.x0;
               py_in       = py_ff + CANVAS_W'(1);
               row_base_in = row_base_ff + STRIDE;
            end
         end
         B_READ: begin
            state_in = B_RESP;
         end
         B_RESP: begin
            if (!op_ff.last || load_rsp) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // result register, one per command
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_rgb_in     = rsp_rgb_ff;
      rsp_outside_in = rsp_outside_ff;
      if (load_rsp) begin
         rsp_valid_in   = 1'b1;
         rsp_outside_in = (op_ff.kind == OP_READ) && op_ff.outside;
         rsp_rgb_in     = ((op_ff.kind == OP_READ) && !op_ff.outside) ? rd_data_ff : '0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_INIT;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      px_ff          <= px_in;
      py_ff          <= py_in;
      row_base_ff    <= row_base_in;
      rsp_rgb_ff     <= rsp_rgb_in;
      rsp_outside_ff <= rsp_outside_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[mem_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= frame_mem[mem_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rect_and_digit_rasterizer_top.sv =====
// channel   direction  handshake              payload
// req       in         req_tvalid/req_tready  tdata: x_pos y_biased rect_width rect_height
//                                             glyph_scale glyph_digit color, tuser: func
// rsp       out        rsp_tvalid/rsp_tready  tdata: read_rgb, tuser: read_outside
// csr       in         csr_valid/csr_ready    csr_index, csr_data (canvas width, height)
//
// the back engine works on one block at a time and paints one pixel per cycle; a digit
// is split into 15 glyph cells, each its own block, and a read is one block; the single
// write port of the frame store sets the pace
// after reset a clearing pass writes black to all MAX_WIDTH*MAX_HEIGHT pixels, one per
// cycle, and no command is taken until it ends; csr writes are taken at any time
// the front takes a command whenever it is idle and holds it until the op queue has room
// for its ops; a held result stalls the back engine at the end of the next command
`default_nettype none

module rect_and_digit_rasterizer_top
   import rdr_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
)(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // command stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // x_pos[11:0] y_biased[24:12] rect_width[36:25] rect_height[48:37]
   // glyph_scale[56:49] glyph_digit[60:57] color[84:61] zero[87:85]
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   // func[1:0]
   input  wire logic [FUNC_W-1:0]      req_tuser,
   // result stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // read_rgb[23:0]
   output logic [RGB_W-1:0]            rsp_tdata,
   // read_outside[0]
   output logic                        rsp_tuser,
   // register writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CANVAS_W-1:0]    csr_data
);

   op_type q_in_data, q_out_data;
   logic   q_push, q_full, q_pop, q_valid;
   logic   engine_ready;

   // canvas registers live in the front and are always writable
   assign csr_ready = 1'b1;

   // front: takes commands, splits digits into cells, clips each block
   rdr_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .engine_ready (engine_ready),
      .q_push       (q_push),
      .q_data       (q_in_data),
      .q_full       (q_full)
   );

   // short op queue between classification and drawing
   rdr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_out_data)
   );

   // back: owns the frame store, paints one pixel a cycle, answers reads
   rdr_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .engine_ready (engine_ready),
      .q_valid      (q_valid),
      .q_data       (q_out_data),
      .q_pop        (q_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

`default_nettype wire
